// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the padder RTL.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge out of reset.
`define SMP_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Condition must never be seen at a clock edge out of reset.
`define SMP_ASSERT_NEVER(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");

`endif

// ===== hdl/smp_pkg.sv =====
// Shared types and constants of the SHA message padder.
// No dependencies; used by every module of the block.
package smp_pkg;

  localparam int WORD_W   = 64;
  localparam int ACC_W    = 56;
  localparam int POS_W    = 6;
  localparam int IDX_W    = 3;

  localparam logic [7:0]       PAD_BYTE      = 8'h80;
  localparam logic [IDX_W-1:0] LAST_BYTE_REM = 3'd7;
  localparam logic [IDX_W-1:0] LAST_ZERO_IDX = 3'd6;
  localparam logic [IDX_W-1:0] LEN_IDX       = 3'd7;
  localparam logic [WORD_W-1:0] BITS_PER_BYTE = 64'd8;

  // Queue between front and back.
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Work handed from the front to the back: an optional finished data word,
  // an optional padding tail, an optional length word, in that order.
  typedef struct packed {
    logic              data_vld;
    logic [WORD_W-1:0] data_word;
    logic [IDX_W-1:0]  data_idx;
    logic              tail_vld;
    logic [WORD_W-1:0] pad_word;
    logic [IDX_W-1:0]  pad_idx;
    logic              len_vld;
    logic [WORD_W-1:0] length;
  } job_t;

endpackage

// ===== hdl/smp_front.sv =====
// Front of the padder: packs bytes, counts bits, classifies each item into a job.
// Depends on smp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module smp_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  acc_en,
  input  logic [7:0]            msg_byte,
  input  logic                  has_byte,
  input  logic                  is_last,
  output logic                  push,
  output smp_pkg::job_t         push_job
);

  logic [smp_pkg::WORD_W-1:0] bc_r, bc_nxt;
  logic [smp_pkg::ACC_W-1:0]  acc_r, acc_nxt;
  logic [smp_pkg::POS_W-1:0]  bib_r, bib_nxt;
  logic                       fin_r, fin_nxt;
  logic                       pend_r, pend_nxt;

  logic [smp_pkg::ACC_W-1:0]  acc1;
  logic [smp_pkg::POS_W-1:0]  bib1;
  logic [smp_pkg::IDX_W-1:0]  rem1;
  logic [5:0]                 pad_sh;
  smp_pkg::job_t              job;

  always_comb begin
    job      = '0;
    bc_nxt   = bc_r;
    acc_nxt  = acc_r;
    bib_nxt  = bib_r;
    fin_nxt  = fin_r;
    pend_nxt = pend_r;
    acc1     = acc_r;
    bib1     = bib_r;
    rem1     = '0;
    pad_sh   = '0;
    if (fin_r) begin
      // Ten-word tail: the length word rides on the next item.
      if (pend_r) begin
        job.len_vld = 1'b1;
        job.length  = bc_r;
        pend_nxt    = 1'b0;
      end
    end else begin
      if (has_byte) begin
        bc_nxt = bc_r + smp_pkg::BITS_PER_BYTE;
        if (bib_r[2:0] == smp_pkg::LAST_BYTE_REM) begin
          job.data_vld  = 1'b1;
          job.data_word = {acc_r, msg_byte};
          job.data_idx  = bib_r[5:3];
          acc1          = '0;
        end else begin
          acc1 = {acc_r[smp_pkg::ACC_W-9:0], msg_byte};
        end
        bib1 = bib_r + 6'd1;
      end
      acc_nxt = acc1;
      bib_nxt = bib1;
      if (is_last) begin
        rem1         = bib1[2:0];
        pad_sh       = {smp_pkg::LAST_BYTE_REM - rem1, 3'b000};
        job.tail_vld = 1'b1;
        job.pad_word = {acc1, smp_pkg::PAD_BYTE} << pad_sh;
        job.pad_idx  = bib1[5:3];
        job.length   = bc_nxt;
        fin_nxt      = 1'b1;
        acc_nxt      = '0;
        bib_nxt      = '0;
        // A word plus a pad in the last slot leaves no room for the length.
        pend_nxt     = job.data_vld && (bib1[5:3] == smp_pkg::LEN_IDX);
        job.len_vld  = !pend_nxt;
      end
    end
  end

  assign push     = acc_en && (job.data_vld || job.tail_vld || job.len_vld);
  assign push_job = job;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bc_r   <= '0;
      acc_r  <= '0;
      bib_r  <= '0;
      fin_r  <= 1'b0;
      pend_r <= 1'b0;
    end else if (acc_en) begin
      bc_r   <= bc_nxt;
      acc_r  <= acc_nxt;
      bib_r  <= bib_nxt;
      fin_r  <= fin_nxt;
      pend_r <= pend_nxt;
    end
  end

  `SMP_ASSERT(a_pend_needs_fin, !pend_r || fin_r)

endmodule

// ===== hdl/smp_queue.sv =====
// Short job queue between the front and the back of the padder.
// Depends on smp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module smp_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  smp_pkg::job_t push_job,
  output logic          full,
  output logic          head_vld,
  output smp_pkg::job_t head_job,
  input  logic          pop
);

  smp_pkg::job_t                mem_r [smp_pkg::QDEPTH];
  logic [smp_pkg::QPTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [smp_pkg::QCNT_W-1:0]   cnt_r;

  function automatic logic [smp_pkg::QPTR_W-1:0] ptr_inc(
    input logic [smp_pkg::QPTR_W-1:0] p
  );
    if (p == smp_pkg::QPTR_W'(smp_pkg::QDEPTH - 1)) begin
      return '0;
    end
    return p + smp_pkg::QPTR_W'(1);
  endfunction

  assign full     = (cnt_r == smp_pkg::QCNT_W'(smp_pkg::QDEPTH));
  assign head_vld = (cnt_r != '0);
  assign head_job = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      unique case ({push, pop})
        2'b10:   cnt_r <= cnt_r + smp_pkg::QCNT_W'(1);
        2'b01:   cnt_r <= cnt_r - smp_pkg::QCNT_W'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  `SMP_ASSERT_NEVER(a_push_when_full, push && full && !pop)
  `SMP_ASSERT_NEVER(a_pop_when_empty, pop && !head_vld)

endmodule

// ===== hdl/smp_back.sv =====
// Back of the padder: expands each job into output words, one per cycle while out_ready is high.
// Depends on smp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module smp_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       head_vld,
  input  smp_pkg::job_t              head_job,
  output logic                       pop,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [smp_pkg::WORD_W-1:0] out_word,
  output logic [smp_pkg::IDX_W-1:0]  out_word_index,
  output logic                       out_block_end,
  output logic                       out_msg_end
);

  typedef enum logic [2:0] {
    PH_START,
    PH_WORD,
    PH_PAD,
    PH_ZERO,
    PH_LEN
  } phase_t;

  phase_t                      ph_r, ph_nxt, cur_ph, first_ph;
  logic [smp_pkg::IDX_W-1:0]   zidx_r, zidx_nxt;
  logic                        out_valid_r;
  logic [smp_pkg::WORD_W-1:0]  out_word_r;
  logic [smp_pkg::IDX_W-1:0]   out_idx_r;
  logic                        out_msg_end_r;

  logic                        load, emit, done;
  logic [smp_pkg::WORD_W-1:0]  w;
  logic [smp_pkg::IDX_W-1:0]   idx;
  logic                        w_end;

  always_comb begin
    first_ph = head_job.data_vld ? PH_WORD : (head_job.tail_vld ? PH_PAD : PH_LEN);
    cur_ph   = (ph_r == PH_START && head_vld) ? first_ph : ph_r;
    load     = !out_valid_r || out_ready;
    emit     = head_vld && load;
    ph_nxt   = ph_r;
    zidx_nxt = zidx_r;
    done     = 1'b0;
    w        = '0;
    idx      = '0;
    w_end    = 1'b0;
    unique case (cur_ph)
      PH_WORD: begin
        w   = head_job.data_word;
        idx = head_job.data_idx;
        if (head_job.tail_vld) begin
          ph_nxt = PH_PAD;
        end else if (head_job.len_vld) begin
          ph_nxt = PH_LEN;
        end else begin
          done = 1'b1;
        end
      end
      PH_PAD: begin
        w   = head_job.pad_word;
        idx = head_job.pad_idx;
        if (head_job.pad_idx != smp_pkg::LAST_ZERO_IDX) begin
          // Zeros start after the pad, wrapping to word 0 of a new block.
          ph_nxt   = PH_ZERO;
          zidx_nxt = head_job.pad_idx + smp_pkg::IDX_W'(1);
        end else if (head_job.len_vld) begin
          ph_nxt = PH_LEN;
        end else begin
          done = 1'b1;
        end
      end
      PH_ZERO: begin
        idx = zidx_r;
        if (zidx_r == smp_pkg::LAST_ZERO_IDX) begin
          if (head_job.len_vld) begin
            ph_nxt = PH_LEN;
          end else begin
            done = 1'b1;
          end
        end else begin
          zidx_nxt = zidx_r + smp_pkg::IDX_W'(1);
        end
      end
      PH_LEN: begin
        w     = head_job.length;
        idx   = smp_pkg::LEN_IDX;
        w_end = 1'b1;
        done  = 1'b1;
      end
      PH_START: begin
        done = 1'b0;
      end
    endcase
    if (done) begin
      ph_nxt = PH_START;
    end
  end

  assign pop = emit && done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r        <= PH_START;
      zidx_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (emit) begin
        ph_r   <= ph_nxt;
        zidx_r <= zidx_nxt;
      end
      if (load) begin
        out_valid_r <= emit;
      end
    end
    if (emit) begin
      out_word_r    <= w;
      out_idx_r     <= idx;
      out_msg_end_r <= w_end;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_word       = out_word_r;
  assign out_word_index = out_idx_r;
  assign out_block_end  = (out_idx_r == smp_pkg::LEN_IDX);
  assign out_msg_end    = out_msg_end_r;

  `SMP_ASSERT(a_end_in_last_slot,
              !(out_valid_r && out_msg_end_r) || (out_idx_r == smp_pkg::LEN_IDX))

endmodule

// ===== hdl/sha_message_padder_unit.sv =====
// Top level of the SHA message padder: front, job queue and word back end.
// Depends on smp_pkg, smp_front, smp_queue and smp_back.

// The padder takes at most one message byte per item and returns the padded
// message as 64-bit big-endian words, eight to a 512-bit block, with word_index
// giving the slot and block_end marking slot 7. An item with is_last set closes
// the message: the block gets byte 0x80, zero words up to slot 6 (running into
// an extra block when fewer than 9 bytes remain) and the 64-bit bit length in
// slot 7 with msg_end set. After that every item is taken and dropped until
// reset. When the last byte lands in byte 55 of a block together with is_last,
// the length word is held back and comes out on the next item, whatever it
// carries. Input rate is one item per cycle: in_ready falls only when the
// two-entry job queue is full. Output rate is one word per cycle while
// out_ready is high; a data word passes through the job queue and the output
// register before it shows on the output. One job expands to at most nine words
// (data word, pad and zeros, or pad, zeros and length) and drains at one word
// per cycle while out_ready is high; the input stalls only when a second job
// arrives meanwhile and fills the queue, as the held length word does behind a
// ten-word tail. out_valid is a registered output, so a stall on the output
// side never blocks the front until the queue fills.
module sha_message_padder_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [7:0]                 in_msg_byte,
  input  logic                       in_has_byte,
  input  logic                       in_is_last,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [smp_pkg::WORD_W-1:0] out_word,
  output logic [smp_pkg::IDX_W-1:0]  out_word_index,
  output logic                       out_block_end,
  output logic                       out_msg_end
);

  logic          q_full;
  logic          acc_en;
  logic          push;
  smp_pkg::job_t push_job;
  logic          head_vld;
  smp_pkg::job_t head_job;
  logic          pop;

  // Take an item whenever the queue has room for the job it may produce.
  assign in_ready = !q_full;
  assign acc_en   = in_valid && in_ready;

  smp_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .acc_en   (acc_en),
    .msg_byte (in_msg_byte),
    .has_byte (in_has_byte),
    .is_last  (in_is_last),
    .push     (push),
    .push_job (push_job)
  );

  smp_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .head_vld (head_vld),
    .head_job (head_job),
    .pop      (pop)
  );

  smp_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head_vld       (head_vld),
    .head_job       (head_job),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_word       (out_word),
    .out_word_index (out_word_index),
    .out_block_end  (out_block_end),
    .out_msg_end    (out_msg_end)
  );

endmodule
